FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge except while reset is high
`define FSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included
`define FSP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types, constants and helpers of the format string number printer.
// ----------------------------------------------------------------------------
package fsp_pkg;

   // Value width; arguments wider than 32 bits are not carried.
   localparam int VALUE_BITS = 32;
   localparam int ARG_BITS   = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
   localparam logic [31:0] ARG_MASK =
      (ARG_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ARG_BITS) - 64'd1);

   // Most digits one value can print (octal of 32 bits)
   localparam int DIGIT_MAX = 11;
   localparam int CNT_W     = $clog2(DIGIT_MAX + 1);
   localparam int DIG_IDX_W = $clog2(DIGIT_MAX);

   // Command queue between front and back; depth must be a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // floor(v / 10) == (v * RECIP_DEC) >> 35 for every 32-bit v
   localparam logic [31:0] RECIP_DEC = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   // ASCII codes
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UP_A    = 8'h41;
   localparam logic [7:0] CHAR_UP_F    = 8'h46;
   localparam logic [7:0] CHAR_UP_X    = 8'h58;
   localparam logic [7:0] CHAR_LOW_C   = 8'h63;
   localparam logic [7:0] CHAR_LOW_D   = 8'h64;
   localparam logic [7:0] CHAR_LOW_H   = 8'h68;
   localparam logic [7:0] CHAR_LOW_I   = 8'h69;
   localparam logic [7:0] CHAR_LOW_L   = 8'h6C;
   localparam logic [7:0] CHAR_LOW_O   = 8'h6F;
   localparam logic [7:0] CHAR_LOW_P   = 8'h70;
   localparam logic [7:0] CHAR_LOW_U   = 8'h75;
   localparam logic [7:0] CHAR_LOW_X   = 8'h78;

   // Command kinds
   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_NUM  = 1'b1;

   // Radix codes
   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_HEX = 2'd1;
   localparam logic [1:0] RADIX_OCT = 2'd2;

   typedef struct packed {
      logic        kind;
      logic [7:0]  ch;
      logic [31:0] mag;
      logic [1:0]  radix;
      logic        neg;
   } cmd_type;

   // Digit value to its character in 0-9, A-F
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] d8;
      d8 = {4'b0, d};
      if (d < 4'd10) begin
         digit_char = CHAR_ZERO + d8;
      end else begin
         digit_char = CHAR_UP_A + d8 - 8'd10;
      end
   endfunction

endpackage

FILE: rtl/core/fsp_front.sv
// ----------------------------------------------------------------------------
// fsp_front
// Format parser: takes one format byte per beat and queues a command for
// every byte that prints something.
// ----------------------------------------------------------------------------
module fsp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_fmt_char,
   input  logic [31:0]        req_arg_value,
   input  logic               q_full,
   output logic               push,
   output fsp_pkg::cmd_type   push_cmd
);

   localparam logic [2:0] PH_NORMAL = 3'd0;
   localparam logic [2:0] PH_LENGTH = 3'd1;
   localparam logic [2:0] PH_SHORT  = 3'd2;
   localparam logic [2:0] PH_LONG   = 3'd3;
   localparam logic [2:0] PH_SPEC   = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic        accept;
   logic        spec_emit;
   logic        is_spec;
   logic [31:0] val;
   logic [31:0] mag_signed;
   logic        sign;
   fsp_pkg::cmd_type spec_cmd;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   assign val        = req_arg_value & fsp_pkg::ARG_MASK;
   assign sign       = val[fsp_pkg::ARG_BITS-1];
   assign mag_signed = sign ? ((~val + 32'd1) & fsp_pkg::ARG_MASK) : val;

   // Conversion specifier decode
   always_comb begin
      spec_cmd       = '0;
      spec_cmd.kind  = fsp_pkg::CMD_NUM;
      spec_cmd.mag   = val;
      spec_cmd.radix = fsp_pkg::RADIX_DEC;
      spec_emit      = 1'b1;
      case (req_fmt_char) inside
         fsp_pkg::CHAR_LOW_C: begin
            spec_cmd.kind = fsp_pkg::CMD_CHAR;
            spec_cmd.ch   = req_arg_value[7:0];
         end
         fsp_pkg::CHAR_PERCENT: begin
            spec_cmd.kind = fsp_pkg::CMD_CHAR;
            spec_cmd.ch   = fsp_pkg::CHAR_PERCENT;
         end
         fsp_pkg::CHAR_LOW_D, fsp_pkg::CHAR_LOW_I: begin
            spec_cmd.mag = mag_signed;
            spec_cmd.neg = sign;
         end
         fsp_pkg::CHAR_LOW_U: begin
            spec_cmd.radix = fsp_pkg::RADIX_DEC;
         end
         fsp_pkg::CHAR_LOW_X, fsp_pkg::CHAR_UP_X, fsp_pkg::CHAR_LOW_P: begin
            spec_cmd.radix = fsp_pkg::RADIX_HEX;
         end
         fsp_pkg::CHAR_LOW_O: begin
            spec_cmd.radix = fsp_pkg::RADIX_OCT;
         end
         default: begin
            spec_emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      is_spec  = 1'b0;
      push     = 1'b0;
      push_cmd = spec_cmd;
      if (accept) begin
         if (req_fmt_char == fsp_pkg::CHAR_NUL) begin
            phase_in = PH_NORMAL;
         end else begin
            case (phase_ff)
               PH_NORMAL: begin
                  if (req_fmt_char == fsp_pkg::CHAR_PERCENT) begin
                     phase_in = PH_LENGTH;
                  end else begin
                     push          = 1'b1;
                     push_cmd      = '0;
                     push_cmd.kind = fsp_pkg::CMD_CHAR;
                     push_cmd.ch   = req_fmt_char;
                  end
               end
               PH_LENGTH: begin
                  if (req_fmt_char == fsp_pkg::CHAR_LOW_H) begin
                     phase_in = PH_SHORT;
                  end else if (req_fmt_char == fsp_pkg::CHAR_LOW_L) begin
                     phase_in = PH_LONG;
                  end else begin
                     is_spec = 1'b1;
                  end
               end
               PH_SHORT: begin
                  if (req_fmt_char == fsp_pkg::CHAR_LOW_H) begin
                     phase_in = PH_SPEC;
                  end else begin
                     is_spec = 1'b1;
                  end
               end
               PH_LONG: begin
                  if (req_fmt_char == fsp_pkg::CHAR_LOW_L) begin
                     phase_in = PH_SPEC;
                  end else begin
                     is_spec = 1'b1;
                  end
               end
               default: begin
                  is_spec = 1'b1;
               end
            endcase
            if (is_spec) begin
               phase_in = PH_NORMAL;
               push     = spec_emit;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: rtl/core/fsp_queue.sv
// ----------------------------------------------------------------------------
// fsp_queue
// Short command FIFO between the parser and the printer.
// ----------------------------------------------------------------------------
module fsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fsp_pkg::cmd_type   push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output fsp_pkg::cmd_type   head_cmd
);

   fsp_pkg::cmd_type entry_ff [fsp_pkg::QUEUE_DEPTH];
   logic [fsp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fsp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fsp_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full       = (count_ff == fsp_pkg::QCNT_W'(fsp_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + fsp_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + fsp_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + fsp_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - fsp_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/core/fsp_back.sv
// ----------------------------------------------------------------------------
// fsp_back
// Printer: turns queued commands into characters. Numbers are split into
// digits least significant first, one per cycle, then sent most
// significant first through the output register.
// ----------------------------------------------------------------------------
module fsp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  fsp_pkg::cmd_type   head_cmd,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_char,
   output logic               rsp_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SIGN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] value_ff, value_in;
   logic [1:0]  radix_ff, radix_in;
   logic        neg_ff, neg_in;
   logic [fsp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]  digit_ff [fsp_pkg::DIGIT_MAX];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_char_ff, rsp_char_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        out_free;
   logic [63:0] prod;
   logic [31:0] q_dec;
   logic [3:0]  ten_q_lo;
   logic [31:0] q_next;
   logic [3:0]  d_next;
   logic [fsp_pkg::DIG_IDX_W-1:0] rd_idx;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Divide by ten through the reciprocal; remainder needs only low bits
   assign prod     = {32'b0, value_ff} * {32'b0, fsp_pkg::RECIP_DEC};
   assign q_dec    = 32'(prod >> fsp_pkg::RECIP_SHIFT);
   assign ten_q_lo = {q_dec[0], 3'b0} + {q_dec[2:0], 1'b0};

   always_comb begin
      case (radix_ff)
         fsp_pkg::RADIX_HEX: begin
            q_next = value_ff >> 4;
            d_next = value_ff[3:0];
         end
         fsp_pkg::RADIX_OCT: begin
            q_next = value_ff >> 3;
            d_next = {1'b0, value_ff[2:0]};
         end
         default: begin
            q_next = q_dec;
            d_next = value_ff[3:0] - ten_q_lo;
         end
      endcase
   end

   assign rd_idx = fsp_pkg::DIG_IDX_W'(cnt_ff - fsp_pkg::CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      radix_in     = radix_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (head_cmd.kind == fsp_pkg::CMD_CHAR) begin
                  if (out_free) begin
                     pop          = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_char_in  = head_cmd.ch;
                     rsp_last_in  = 1'b1;
                  end
               end else begin
                  pop      = 1'b1;
                  value_in = head_cmd.mag;
                  radix_in = head_cmd.radix;
                  neg_in   = head_cmd.neg;
                  cnt_in   = '0;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            value_in = q_next;
            cnt_in   = cnt_ff + fsp_pkg::CNT_W'(1);
            if (q_next == '0) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = fsp_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = fsp_pkg::digit_char(digit_ff[rd_idx]);
               rsp_last_in  = (cnt_ff == fsp_pkg::CNT_W'(1));
               cnt_in       = cnt_ff - fsp_pkg::CNT_W'(1);
               if (cnt_ff == fsp_pkg::CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      radix_ff    <= radix_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (state_ff == ST_CONV) begin
         digit_ff[cnt_ff[fsp_pkg::DIG_IDX_W-1:0]] <= d_next;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

FILE: rtl/core/format_string_number_printer_core.sv
// ----------------------------------------------------------------------------
// format_string_number_printer_core
// printf-style format interpreter with integer radix conversion.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one format byte (req_fmt_char) per beat with its argument
//   word (req_arg_value), read only when the byte completes a conversion.
//   rsp channel: one output character per beat; rsp_last marks the final
//   character caused by an input byte. Bytes that print nothing (percent,
//   length marks, NUL, unknown specifiers) give no rsp beat.
//   Path: a plain character passes through the command queue and then the
//   output register to rsp. The printer pulls a number from the queue,
//   splits it into digits (one divide-by-radix step per cycle, using one
//   32x32 reciprocal multiply for decimal), then sends a minus sign beat if
//   negative and one beat per digit, at most 11 digits (octal). It takes
//   the next command only after the last digit beat. The parser keeps
//   accepting bytes into a two-entry command queue while the printer
//   works, so parsing overlaps printing until the queue fills.
//   Reset (synchronous) returns the parser to plain text and empties the
//   queue and output register. A stalled rsp_ready holds the current beat;
//   the queue fills and then req_ready drops.
// ----------------------------------------------------------------------------
module format_string_number_printer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_fmt_char,
   input  logic [31:0] req_arg_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last
);

   logic             q_full;
   logic             push;
   fsp_pkg::cmd_type push_cmd;
   logic             pop;
   logic             head_valid;
   fsp_pkg::cmd_type head_cmd;

   fsp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_fmt_char  (req_fmt_char),
      .req_arg_value (req_arg_value),
      .q_full        (q_full),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   fsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   fsp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule

FILE: rtl/core/fsp_checker.sv
// ----------------------------------------------------------------------------
// fsp_checker
// Port-level checks of the format printer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last
);

   `FSP_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   `FSP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last), "stalled rsp beat changed")

   // Only a sign or a digit can be followed by more characters of the same byte
   `FSP_ASSERT(a_non_last_is_digit, clock, reset, rsp_valid && !rsp_last |-> (rsp_out_char == fsp_pkg::CHAR_MINUS) || (rsp_out_char >= fsp_pkg::CHAR_ZERO && rsp_out_char <= fsp_pkg::CHAR_NINE) || (rsp_out_char >= fsp_pkg::CHAR_UP_A && rsp_out_char <= fsp_pkg::CHAR_UP_F), "non-final beat is not a digit")

   // A minus sign that is taken is not followed by a second minus sign
   `FSP_ASSERT(a_minus_then_digit, clock, reset, rsp_valid && rsp_ready && !rsp_last && rsp_out_char == fsp_pkg::CHAR_MINUS |=> !(rsp_valid && rsp_out_char == fsp_pkg::CHAR_MINUS), "minus sign repeated")

endmodule

bind format_string_number_printer_core fsp_checker u_fsp_checker (.*);
